// File: src/amr_pkg.sv
// Shared constants, types and compare helpers for the argmin/argmax reduction.
package amr_pkg;

    localparam int unsigned ElemWidth  = 32;
    localparam int unsigned IndexWidth = 16;
    localparam longint unsigned DefaultMaxRowLen = 64'd65536;
    localparam int unsigned QueueDepth = 2;

    typedef enum logic [1:0] {
        FMT_INT32 = 2'd0,
        FMT_FP32  = 2'd1,
        FMT_FP16  = 2'd2,
        FMT_BF16  = 2'd3
    } fmt_t;

    localparam logic CFG_MODE_MAX = 1'b0;
    localparam logic CFG_FORMAT   = 1'b1;

    // Classified item as it crosses from the front part to the back part.
    // The format travels along so the held element is judged the same way.
    typedef struct packed {
        logic [ElemWidth-1:0]  value;
        logic signed [ElemWidth:0] key;
        logic                  is_nan;
        logic                  last;
        logic                  mode_max;
        fmt_t                  fmt;
    } cls_item_t;

    function automatic logic [ElemWidth-1:0] fmt_bits(input fmt_t fmt,
                                                      input logic [ElemWidth-1:0] b);
        logic [ElemWidth-1:0] r;
        begin
            r = b;
            if (fmt == FMT_FP16 || fmt == FMT_BF16)
            begin
                r = {16'h0000, b[15:0]};
            end
            return r;
        end
    endfunction

    function automatic logic nan_of(input fmt_t fmt, input logic [ElemWidth-1:0] b);
        logic r;
        begin
            case (fmt)
                FMT_FP32: r = (&b[30:23]) && (|b[22:0]);
                FMT_FP16: r = (&b[14:10]) && (|b[9:0]);
                FMT_BF16: r = (&b[14:7]) && (|b[6:0]);
                default:  r = 1'b0;
            endcase
            return r;
        end
    endfunction

    // Order key: larger key means larger value; signed zeros map to zero.
    function automatic logic signed [ElemWidth:0] key_of(input fmt_t fmt,
                                                         input logic [ElemWidth-1:0] b);
        logic signed [ElemWidth:0] mag;
        logic signed [ElemWidth:0] r;
        logic                      neg;
        begin
            case (fmt)
                FMT_INT32:
                begin
                    mag = '0;
                    neg = 1'b0;
                    r = {b[31], b};
                end
                FMT_FP32:
                begin
                    mag = {2'b00, b[30:0]};
                    neg = b[31];
                    r = neg ? -mag : mag;
                end
                default:
                begin
                    mag = {18'h0, b[14:0]};
                    neg = b[15];
                    r = neg ? -mag : mag;
                end
            endcase
            return r;
        end
    endfunction

endpackage

// File: src/amr_front.sv
// Front part: accepts items, masks half formats and computes NaN flag and order key.
module amr_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [amr_pkg::ElemWidth-1:0]      in_bits,
    input  logic                               in_last,
    input  logic                               mode_max,
    input  amr_pkg::fmt_t                      fmt,
    output logic                               cls_valid,
    input  logic                               cls_ready,
    output amr_pkg::cls_item_t                 cls_item
);

    logic                 valid_reg;
    logic                 valid_next;
    amr_pkg::cls_item_t   item_reg;
    amr_pkg::cls_item_t   item_next;
    logic [amr_pkg::ElemWidth-1:0] masked;

    assign in_ready  = !valid_reg || cls_ready;
    assign cls_valid = valid_reg;
    assign cls_item  = item_reg;

    always_comb
    begin
        masked             = amr_pkg::fmt_bits(fmt, in_bits);
        item_next.value    = masked;
        item_next.key      = amr_pkg::key_of(fmt, masked);
        item_next.is_nan   = amr_pkg::nan_of(fmt, masked);
        item_next.last     = in_last;
        item_next.mode_max = mode_max;
        item_next.fmt      = fmt;
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// File: src/amr_queue.sv
// Short queue between the front and back parts.
module amr_queue #(
    parameter int unsigned DEPTH = amr_pkg::QueueDepth
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  amr_pkg::cls_item_t wr_item,
    output logic               rd_valid,
    input  logic               rd_ready,
    output amr_pkg::cls_item_t rd_item
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    amr_pkg::cls_item_t   mem [DEPTH];
    logic [PtrW-1:0]      wr_ptr_reg;
    logic [PtrW-1:0]      wr_ptr_next;
    logic [PtrW-1:0]      rd_ptr_reg;
    logic [PtrW-1:0]      rd_ptr_next;
    logic [PtrW:0]        count_reg;
    logic [PtrW:0]        count_next;
    logic                 push;
    logic                 pop;

    assign wr_ready = count_reg < (PtrW+1)'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_item  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: src/amr_back.sv
// Back part: running best compare, position counter and the result register.
module amr_back #(
    parameter longint unsigned MAX_ROW_LEN = amr_pkg::DefaultMaxRowLen
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cls_valid,
    output logic                               cls_ready,
    input  amr_pkg::cls_item_t                 cls_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [amr_pkg::ElemWidth-1:0]      out_value,
    output logic [amr_pkg::IndexWidth-1:0]     out_index
);

    localparam longint unsigned CapRaw = MAX_ROW_LEN - 1;
    localparam logic [amr_pkg::IndexWidth-1:0] PosCap =
        (CapRaw > 65535) ? 16'hFFFF : amr_pkg::IndexWidth'(CapRaw);

    logic [amr_pkg::ElemWidth-1:0]  held_value_reg, held_value_next;
    logic signed [amr_pkg::ElemWidth:0] held_key;
    logic                           held_nan;
    logic [amr_pkg::IndexWidth-1:0] held_index_reg, held_index_next;
    logic [amr_pkg::IndexWidth-1:0] pos_reg, pos_next;
    logic                           open_reg, open_next;
    logic                           out_valid_reg, out_valid_next;
    logic [amr_pkg::ElemWidth-1:0]  out_value_reg;
    logic [amr_pkg::IndexWidth-1:0] out_index_reg;
    logic                           take;
    logic                           keep;
    logic                           fire;
    logic [amr_pkg::ElemWidth-1:0]  win_value;
    logic [amr_pkg::IndexWidth-1:0] win_index;

    assign cls_ready = !out_valid_reg || out_ready;
    assign fire      = cls_valid && cls_ready;
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_index = out_index_reg;

    always_comb
    begin
        // The held element is judged in the format that stands for this item.
        held_key = amr_pkg::key_of(cls_item.fmt, held_value_reg);
        held_nan = amr_pkg::nan_of(cls_item.fmt, held_value_reg);
        // Held element stays on a NaN, or on an equal or better key.
        if (held_nan)
        begin
            keep = 1'b1;
        end
        else if (cls_item.is_nan)
        begin
            keep = 1'b0;
        end
        else if (held_key == cls_item.key)
        begin
            keep = 1'b1;
        end
        else
        begin
            keep = cls_item.mode_max ? (held_key > cls_item.key)
                                     : (held_key < cls_item.key);
        end
        take = !open_reg || !keep;
        win_value = take ? cls_item.value : held_value_reg;
        win_index = take ? pos_reg : held_index_reg;

        held_value_next = held_value_reg;
        held_index_next = held_index_reg;
        pos_next        = pos_reg;
        open_next       = open_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        if (fire)
        begin
            if (cls_item.last)
            begin
                held_value_next = '0;
                held_index_next = '0;
                pos_next        = '0;
                open_next       = 1'b0;
                out_valid_next  = 1'b1;
            end
            else
            begin
                held_value_next = win_value;
                held_index_next = win_index;
                open_next = 1'b1;
                if (pos_reg < PosCap)
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_value_reg <= '0;
            held_index_reg <= '0;
            pos_reg        <= '0;
            open_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            held_value_reg <= held_value_next;
            held_index_reg <= held_index_next;
            pos_reg        <= pos_next;
            open_reg       <= open_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && cls_item.last)
        begin
            out_value_reg <= win_value;
            out_index_reg <= win_index;
        end
    end

endmodule

// File: src/argmin_argmax_reduction.sv
// Top level of the streaming argmin/argmax row reduction.
//
//  channel   | direction | tdata                         | tlast / tuser
//  s_axis    | in        | element_bits[31:0]            | tlast = last_in_row
//  m_axis    | out       | best_value[31:0], best_index  | none
//  cfg       | in        | index 0 mode_max, 1 format    | write only
//
// One item per cycle is accepted while no result waits; the last item of a row
// passes the classify register and then the queue, and then the compare loads
// the result register.
// A waiting result stalls the compare; the queue and the classify register then
// take three more items before the input stalls.
// Reset clears the running state and both configuration registers to zero.
module argmin_argmax_reduction #(
    parameter longint unsigned MAX_ROW_LEN = amr_pkg::DefaultMaxRowLen
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // element_bits[31:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // best_value[31:0], best_index[47:32]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data
);

    logic               mode_max_reg;
    amr_pkg::fmt_t      fmt_reg;
    logic               f_valid, f_ready, b_valid, b_ready;
    amr_pkg::cls_item_t f_item, b_item;
    logic [31:0]        value;
    logic [15:0]        index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_max_reg <= 1'b0;
            fmt_reg      <= amr_pkg::FMT_INT32;
        end
        else if (cfg_we)
        begin
            if (cfg_index == amr_pkg::CFG_MODE_MAX)
            begin
                mode_max_reg <= cfg_data[0];
            end
            else
            begin
                fmt_reg <= amr_pkg::fmt_t'(cfg_data);
            end
        end
    end

    amr_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_bits(s_axis_tdata), .in_last(s_axis_tlast),
        .mode_max(mode_max_reg), .fmt(fmt_reg),
        .cls_valid(f_valid), .cls_ready(f_ready), .cls_item(f_item)
    );

    amr_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
    );

    amr_back #(.MAX_ROW_LEN(MAX_ROW_LEN)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cls_valid(b_valid), .cls_ready(b_ready), .cls_item(b_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_value(value), .out_index(index)
    );

    assign m_axis_tdata = {index, value};

endmodule

// File: test/testbench.sv
// Self-checking testbench for the streaming argmin/argmax row reduction.
module testbench;

    typedef struct {
        logic [31:0] value;
        logic [15:0] index;
    } row_best_t;

    class best_board;
        row_best_t     pending[$];
        int unsigned   errors;
        bit            mode_is_max;
        amr_pkg::fmt_t fmt;
        logic [31:0]   held_value;
        logic [15:0]   held_index;
        logic [15:0]   position;
        bit            row_open;

        function void clear_row();
            held_value = '0;
            held_index = '0;
            position   = '0;
            row_open   = 1'b0;
        endfunction

        function bit elem_is_nan(logic [31:0] b);
            case (fmt)
                amr_pkg::FMT_FP32: return (b[30:23] == 8'hFF) && (b[22:0] != 0);
                amr_pkg::FMT_FP16: return (b[14:10] == 5'h1F) && (b[9:0] != 0);
                amr_pkg::FMT_BF16: return (b[14:7] == 8'hFF) && (b[6:0] != 0);
                default:  return 1'b0;
            endcase
        endfunction

        function longint elem_key(logic [31:0] b);
            longint m;
            if (fmt == amr_pkg::FMT_INT32)
                return longint'($signed(b));
            if (fmt == amr_pkg::FMT_FP32)
            begin
                m = longint'(b[30:0]);
                return b[31] ? -m : m;
            end
            m = longint'(b[14:0]);
            return b[15] ? -m : m;
        endfunction

        function bit held_stays(logic [31:0] h, logic [31:0] n);
            longint kh;
            longint kn;
            if (elem_is_nan(h))
                return 1'b1;
            if (elem_is_nan(n))
                return 1'b0;
            kh = elem_key(h);
            kn = elem_key(n);
            if (kh == kn)
                return 1'b1;
            return mode_is_max ? (kh > kn) : (kh < kn);
        endfunction

        function void note_element(logic [31:0] raw, logic last);
            logic [31:0] e;
            row_best_t r;
            e = (fmt == amr_pkg::FMT_FP16 || fmt == amr_pkg::FMT_BF16) ?
                {16'h0, raw[15:0]} : raw;
            if (!row_open || !held_stays(held_value, e))
            begin
                held_value = e;
                held_index = position;
            end
            row_open = 1'b1;
            if (position != 16'hFFFF)
                position++;
            if (last)
            begin
                r.value = held_value;
                r.index = held_index;
                pending.push_back(r);
                clear_row();
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch: %s got %h expected %h", what, got, want);
            errors++;
        endtask

        task check_result(logic [47:0] d);
            row_best_t r;
            if (pending.size() == 0)
            begin
                report("unexpected result", d[31:0], 32'h0);
                return;
            end
            r = pending.pop_front();
            if (d[31:0] !== r.value)
                report("best_value", d[31:0], r.value);
            if (d[47:32] !== r.index)
                report("best_index", {16'h0, d[47:32]}, {16'h0, r.index});
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_index = amr_pkg::CFG_MODE_MAX;
    logic [1:0]  cfg_data = '0;

    best_board   board;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          recv_hold = 1'b0;
    longint      cycles = 0;

    argmin_argmax_reduction u_dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);

    always @(negedge clk)
        m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);

    task write_reg(logic idx, logic [1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == amr_pkg::CFG_MODE_MAX)
            board.mode_is_max = val[0];
        else
            board.fmt = amr_pkg::fmt_t'(val);
    endtask

    task drain();
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // Holds the item on the bus until it is taken; drive at falling edges only.
    task send_element(logic [31:0] bits, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = bits;
        s_axis_tlast  = last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_element(bits, last);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    function logic [31:0] pick_value(amr_pkg::fmt_t f);
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(7))
            0: v = (f == amr_pkg::FMT_FP32) ? {v[31], 8'hFF, 23'h0}
                                            : {v[31:16], v[15], 15'h7C00};
            1: v = (f == amr_pkg::FMT_FP32) ? {v[31], 8'hFF, v[22:0]}
                                            : {v[31:16], v[15], 8'hFF, v[6:0]};
            2: v = {v[31:16], v[15], 15'h7C00 | v[9:0]};
            3: v = {v[31:16] & {16{v[0]}}, 1'b0, 15'h0} ^ {v[1], 31'h0};
            4: v = {28'h0, v[3:0]};
            default: ;
        endcase
        return v;
    endfunction

    task random_rows(int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
            for (int unsigned k = 0; k < len; k++)
                send_element(pick_value(board.fmt), k == len - 1);
            sent += len;
        end
    endtask

    initial
    begin
        board = new();
        board.clear_row();
        board.fmt = amr_pkg::FMT_INT32;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, signed zeros, infinities, NaN order, single rows.
        send_element(32'h7FFF_FFFF, 1'b0);
        send_element(32'h8000_0000, 1'b0);
        send_element(32'h8000_0000, 1'b1);
        send_element(32'h0000_0005, 1'b1);
        drain();
        write_reg(amr_pkg::CFG_MODE_MAX, 2'd1);
        write_reg(amr_pkg::CFG_FORMAT, 2'd1);
        send_element(32'h8000_0000, 1'b0);
        send_element(32'h0000_0000, 1'b0);
        send_element(32'h7F80_0000, 1'b0);
        send_element(32'h7FC0_0001, 1'b0);
        send_element(32'hFFC0_0002, 1'b1);
        drain();
        write_reg(amr_pkg::CFG_FORMAT, 2'd2);
        send_element(32'hFFFF_FC00, 1'b0);
        send_element(32'hABCD_7C00, 1'b0);
        send_element(32'h0000_7C01, 1'b1);
        drain();
        write_reg(amr_pkg::CFG_MODE_MAX, 2'd0);
        write_reg(amr_pkg::CFG_FORMAT, 2'd3);
        send_element(32'h1234_FF80, 1'b0);
        send_element(32'h0000_8000, 1'b0);
        // Mode flips inside the row, once the earlier items have passed through.
        repeat (6) @(negedge clk);
        write_reg(amr_pkg::CFG_MODE_MAX, 2'd1);
        send_element(32'h0000_7F80, 1'b1);
        drain();

        // Random phases with different idling and register settings.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(amr_pkg::CFG_MODE_MAX, {1'b0, ph[0]});
            write_reg(amr_pkg::CFG_FORMAT, ph[2:1] ^ {1'b0, ph[0]});
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            if (ph == 0)
            begin
                // Long output hold-off so the block backs up its input.
                fork
                    begin
                        recv_hold = 1'b1;
                        repeat (200) @(negedge clk);
                        recv_hold = 1'b0;
                    end
                    random_rows(100);
                join
            end
            else
                random_rows(150);
            drain();
        end

        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
